// ----- src/ewd_pkg.sv -----
// ----------------------------------------------------------------------------
// ewd_pkg
// Shared types and constants for the next-hop route engine.
// ----------------------------------------------------------------------------
package ewd_pkg;

    localparam int MAX_NODES  = 16;
    localparam int IDX_W      = $clog2(MAX_NODES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int COORD_W    = 16;
    localparam int COST_BITS  = 40;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int RAD_W      = 2 * (COORD_W + 1);
    localparam int ROOT_W     = COORD_W + 1;
    localparam int REM_W      = ROOT_W + 3;
    localparam int XSQ_W      = 2 * ROOT_W;
    localparam int WT_W       = XSQ_W + 1;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(ROOT_STEPS);

    localparam logic [ROOT_W-1:0] GROUND_PENALTY = ROOT_W'(1000);
    localparam logic [ROOT_W-1:0] SOFT_LIMIT     = ROOT_W'(500);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ROUTE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEL,
        ST_SEL_END,
        ST_REL_CHK,
        ST_REL_SQ,
        ST_REL_SUM,
        ST_REL_ROOT,
        ST_REL_PEN,
        ST_REL_MUL,
        ST_REL_WT,
        ST_REL_UPD,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic             load;
        logic             route;
        logic             src_ok;
        logic [IDX_W-1:0] idx;
        logic             sel_clr;
        logic             sel_step;
        logic             mark;
        logic             rel_abs;
        logic             rel_sq;
        logic             rel_sum;
        logic             root_step;
        logic             rel_pen;
        logic             rel_mul;
        logic             rel_wt;
        logic             rel_upd;
        logic             emit;
        logic             last;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic found;
        logic reach_u;
        logic rel_skip;
    } t_status;

endpackage

// ----- src/euclid_weight_dijkstra_next_hop.sv -----
// ----------------------------------------------------------------------------
// euclid_weight_dijkstra_next_hop
// Dense shortest-path engine with distance based link weights.
// ----------------------------------------------------------------------------
// Load item: stored at its accept edge, busy stays low, no result.
// Route item over n nodes: n+1 selection scans, plus one relax scan per reached
//   node, which skips done entries and ground-to-ground pairs and runs every
//   other linked entry through the 17-step bit-serial square root. Then n
//   results, one per cycle, o_valid strobed; busy drops after the last one;
//   the receiver cannot stall.
// Reset (synchronous, active low): idle, node_count = 1; node stores undefined.
// ----------------------------------------------------------------------------
module euclid_weight_dijkstra_next_hop (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cmd,
    input  logic [ewd_pkg::IDX_W-1:0]           i_node_index,
    input  logic signed [ewd_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [ewd_pkg::COORD_W-1:0]  i_coord_y,
    input  logic                                i_is_ground,
    // node_count register
    input  logic                                i_cfg_we,
    input  logic [ewd_pkg::CNT_W-1:0]           i_cfg_data,
    // results, one item per node in ascending order
    output logic                                o_valid,
    output logic [ewd_pkg::IDX_W-1:0]           o_dest_index,
    output logic [ewd_pkg::IDX_W-1:0]           o_first_hop,
    output logic [ewd_pkg::COST_BITS-1:0]       o_path_cost,
    output logic                                o_reachable,
    output logic                                o_last
);

    ewd_pkg::t_cmd    cmd;
    ewd_pkg::t_status status;

    // sequencer: owns the scan index, node count and step counters
    ewd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_node_index (i_node_index),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    // stores, selection, weight unit and result register
    ewd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_node_index (i_node_index),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_is_ground  (i_is_ground),
        .o_status     (status),
        .o_valid      (o_valid),
        .o_dest_index (o_dest_index),
        .o_first_hop  (o_first_hop),
        .o_path_cost  (o_path_cost),
        .o_reachable  (o_reachable),
        .o_last       (o_last)
    );

endmodule

// ----- src/ewd_ctrl.sv -----
// ----------------------------------------------------------------------------
// ewd_ctrl
// Sequencer: selection scans, relax scans, weight steps and result sweep.
// ----------------------------------------------------------------------------
module ewd_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cmd,
    input  logic [ewd_pkg::IDX_W-1:0]     i_node_index,
    input  logic                          i_cfg_we,
    input  logic [ewd_pkg::CNT_W-1:0]     i_cfg_data,
    input  ewd_pkg::t_status              i_status,
    output ewd_pkg::t_cmd                 o_cmd
);

    ewd_pkg::t_state                 r_state, n_state;
    logic [ewd_pkg::CNT_W-1:0]       r_node_count;
    logic [ewd_pkg::CNT_W-1:0]       r_n, n_n;
    logic [ewd_pkg::IDX_W-1:0]       r_j, n_j;
    logic [ewd_pkg::STEP_W-1:0]      r_k, n_k;
    logic [ewd_pkg::CNT_W-1:0]       active_n;
    logic                            j_last;
    logic                            accept;

    // clamp node count to 1..MAX_NODES
    always_comb begin
        if (r_node_count == '0) begin
            active_n = ewd_pkg::CNT_W'(1);
        end else if (r_node_count > ewd_pkg::CNT_W'(ewd_pkg::MAX_NODES)) begin
            active_n = ewd_pkg::CNT_W'(ewd_pkg::MAX_NODES);
        end else begin
            active_n = r_node_count;
        end
    end

    assign busy   = (r_state != ewd_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign j_last = ({1'b0, r_j} == (r_n - ewd_pkg::CNT_W'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ewd_pkg::ST_IDLE;
            r_node_count <= ewd_pkg::CNT_W'(1);
            r_n          <= ewd_pkg::CNT_W'(1);
            r_j          <= '0;
            r_k          <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_j     <= n_j;
            r_k     <= n_k;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_j     = r_j;
        n_k     = r_k;
        o_cmd   = '0;
        o_cmd.idx    = r_j;
        o_cmd.src_ok = ({1'b0, i_node_index} < active_n);
        o_cmd.last   = j_last;
        case (r_state)
            ewd_pkg::ST_IDLE: begin
                if (accept && i_cmd == ewd_pkg::CMD_LOAD) begin
                    o_cmd.load = 1'b1;
                end else if (accept) begin
                    o_cmd.route   = 1'b1;
                    o_cmd.sel_clr = 1'b1;
                    n_n     = active_n;
                    n_j     = '0;
                    n_state = ewd_pkg::ST_SEL;
                end
            end
            ewd_pkg::ST_SEL: begin
                o_cmd.sel_step = 1'b1;
                n_j = r_j + 1'b1;
                if (j_last) begin
                    n_j     = '0;
                    n_state = ewd_pkg::ST_SEL_END;
                end
            end
            ewd_pkg::ST_SEL_END: begin
                n_j = '0;
                if (!i_status.found) begin
                    n_state = ewd_pkg::ST_OUT;
                end else begin
                    o_cmd.mark    = 1'b1;
                    o_cmd.sel_clr = 1'b1;
                    n_state = i_status.reach_u ? ewd_pkg::ST_REL_CHK : ewd_pkg::ST_SEL;
                end
            end
            ewd_pkg::ST_REL_CHK: begin
                if (i_status.rel_skip) begin
                    n_j = r_j + 1'b1;
                    if (j_last) begin
                        n_j     = '0;
                        n_state = ewd_pkg::ST_SEL;
                    end
                end else begin
                    o_cmd.rel_abs = 1'b1;
                    n_state = ewd_pkg::ST_REL_SQ;
                end
            end
            ewd_pkg::ST_REL_SQ: begin
                o_cmd.rel_sq = 1'b1;
                n_state = ewd_pkg::ST_REL_SUM;
            end
            ewd_pkg::ST_REL_SUM: begin
                o_cmd.rel_sum = 1'b1;
                n_k     = '0;
                n_state = ewd_pkg::ST_REL_ROOT;
            end
            ewd_pkg::ST_REL_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_k = r_k + 1'b1;
                if (r_k == ewd_pkg::STEP_W'(ewd_pkg::ROOT_STEPS - 1)) begin
                    n_state = ewd_pkg::ST_REL_PEN;
                end
            end
            ewd_pkg::ST_REL_PEN: begin
                o_cmd.rel_pen = 1'b1;
                n_state = ewd_pkg::ST_REL_MUL;
            end
            ewd_pkg::ST_REL_MUL: begin
                o_cmd.rel_mul = 1'b1;
                n_state = ewd_pkg::ST_REL_WT;
            end
            ewd_pkg::ST_REL_WT: begin
                o_cmd.rel_wt = 1'b1;
                n_state = ewd_pkg::ST_REL_UPD;
            end
            ewd_pkg::ST_REL_UPD: begin
                o_cmd.rel_upd = 1'b1;
                n_j     = r_j + 1'b1;
                n_state = ewd_pkg::ST_REL_CHK;
                if (j_last) begin
                    n_j     = '0;
                    n_state = ewd_pkg::ST_SEL;
                end
            end
            ewd_pkg::ST_OUT: begin
                o_cmd.emit = 1'b1;
                n_j = r_j + 1'b1;
                if (j_last) begin
                    n_j     = '0;
                    n_state = ewd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ewd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/ewd_dp.sv -----
// ----------------------------------------------------------------------------
// ewd_dp
// Node stores, selection registers, link weight unit and result register.
// ----------------------------------------------------------------------------
module ewd_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ewd_pkg::t_cmd                     i_cmd,
    input  logic [ewd_pkg::IDX_W-1:0]         i_node_index,
    input  logic signed [ewd_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [ewd_pkg::COORD_W-1:0] i_coord_y,
    input  logic                              i_is_ground,
    output ewd_pkg::t_status                  o_status,
    output logic                              o_valid,
    output logic [ewd_pkg::IDX_W-1:0]         o_dest_index,
    output logic [ewd_pkg::IDX_W-1:0]         o_first_hop,
    output logic [ewd_pkg::COST_BITS-1:0]     o_path_cost,
    output logic                              o_reachable,
    output logic                              o_last
);

    localparam int N  = ewd_pkg::MAX_NODES;
    localparam int IW = ewd_pkg::IDX_W;
    localparam int CW = ewd_pkg::COORD_W;
    localparam int KW = ewd_pkg::COST_BITS;

    // node and route stores, read at the scan index only
    logic [CW-1:0] r_x    [N];
    logic [CW-1:0] r_y    [N];
    logic          r_g    [N];
    logic [KW-1:0] r_cost [N];
    logic [IW-1:0] r_hop  [N];
    logic [N-1:0]  r_done;
    logic [N-1:0]  r_reach;

    logic [IW-1:0] r_src;
    logic          r_found;
    logic          r_found_reach;
    logic [IW-1:0] r_u;
    logic          r_reach_u;
    logic [CW-1:0] r_xu;
    logic [CW-1:0] r_yu;
    logic          r_gu;
    logic [KW-1:0] r_cost_u;
    logic [IW-1:0] r_hop_u;

    // weight unit
    logic [CW-1:0]                  r_ax, r_ay;
    logic                           r_one_gnd;
    logic [ewd_pkg::SQ_W-1:0]       r_sqx, r_sqy;
    logic [ewd_pkg::RAD_W-1:0]      r_rad;
    logic [ewd_pkg::REM_W-1:0]      r_rem;
    logic [ewd_pkg::ROOT_W-1:0]     r_root;
    logic [ewd_pkg::ROOT_W-1:0]     r_d;
    logic [ewd_pkg::ROOT_W-1:0]     r_exc;
    logic                           r_big;
    logic [ewd_pkg::XSQ_W-1:0]      r_xsq;
    logic [ewd_pkg::WT_W-1:0]       r_w;

    logic                           r_valid;
    logic [IW-1:0]                  r_o_dest, r_o_hop;
    logic [KW-1:0]                  r_o_cost;
    logic                           r_o_reach, r_o_last;

    logic [IW-1:0]                  j;
    logic signed [CW:0]             dx, dy;
    logic [CW:0]                    ndx, ndy;
    logic [ewd_pkg::REM_W-1:0]      rem_sh, trial;
    logic [ewd_pkg::ROOT_W-1:0]     d;
    logic [KW:0]                    sum_ext;
    logic [KW-1:0]                  sum;
    logic                           take;

    assign j = i_cmd.idx;

    assign dx  = {r_xu[CW-1], r_xu} - {r_x[j][CW-1], r_x[j]};
    assign dy  = {r_yu[CW-1], r_yu} - {r_y[j][CW-1], r_y[j]};
    assign ndx = -dx;
    assign ndy = -dy;

    assign rem_sh = {r_rem[ewd_pkg::REM_W-3:0], r_rad[ewd_pkg::RAD_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign d      = r_root + (r_one_gnd ? ewd_pkg::GROUND_PENALTY : '0);

    assign sum_ext = {1'b0, r_cost_u} + (KW+1)'(r_w);
    assign sum     = sum_ext[KW] ? '1 : sum_ext[KW-1:0];

    // last index of least cost among reached; unreached only while none reached
    assign take = !r_done[j] &&
                  (r_reach[j] ? (!r_found_reach || r_cost[j] <= r_cost_u) : !r_found_reach);

    assign o_status.found    = r_found;
    assign o_status.reach_u  = r_reach_u;
    assign o_status.rel_skip = r_done[j] || (r_gu && r_g[j]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done        <= '0;
            r_reach       <= '0;
            r_found       <= 1'b0;
            r_found_reach <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.route) begin
                r_done  <= '0;
                // only the source starts reached
                r_reach <= i_cmd.src_ok ? (N'(1) << i_node_index) : '0;
            end
            if (i_cmd.sel_clr) begin
                r_found       <= 1'b0;
                r_found_reach <= 1'b0;
            end
            if (i_cmd.sel_step && take) begin
                r_found <= 1'b1;
                if (r_reach[j]) begin
                    r_found_reach <= 1'b1;
                end
            end
            if (i_cmd.mark) begin
                r_done[r_u] <= 1'b1;
            end
            if (i_cmd.rel_upd && (!r_reach[j] || sum < r_cost[j])) begin
                r_reach[j] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x[i_node_index] <= i_coord_x;
            r_y[i_node_index] <= i_coord_y;
            r_g[i_node_index] <= i_is_ground;
        end
        if (i_cmd.route) begin
            r_src <= i_node_index;
            r_cost[i_node_index] <= '0;
        end
        if (i_cmd.sel_step && take) begin
            r_u       <= j;
            r_reach_u <= r_reach[j];
            r_xu      <= r_x[j];
            r_yu      <= r_y[j];
            r_gu      <= r_g[j];
            r_cost_u  <= r_cost[j];
            r_hop_u   <= r_hop[j];
        end
        if (i_cmd.rel_abs) begin
            r_ax      <= dx[CW] ? ndx[CW-1:0] : dx[CW-1:0];
            r_ay      <= dy[CW] ? ndy[CW-1:0] : dy[CW-1:0];
            r_one_gnd <= r_gu ^ r_g[j];
        end
        if (i_cmd.rel_sq) begin
            r_sqx <= r_ax * r_ax;
            r_sqy <= r_ay * r_ay;
        end
        if (i_cmd.rel_sum) begin
            r_rad  <= ewd_pkg::RAD_W'(r_sqx) + ewd_pkg::RAD_W'(r_sqy);
            r_rem  <= '0;
            r_root <= '0;
        end
        // one root bit per step
        if (i_cmd.root_step) begin
            r_rad <= {r_rad[ewd_pkg::RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ewd_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ewd_pkg::ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.rel_pen) begin
            r_d   <= d;
            r_big <= (d > ewd_pkg::SOFT_LIMIT);
            r_exc <= (d > ewd_pkg::SOFT_LIMIT) ? d - ewd_pkg::SOFT_LIMIT : '0;
        end
        if (i_cmd.rel_mul) begin
            r_xsq <= r_exc * r_exc;
        end
        if (i_cmd.rel_wt) begin
            r_w <= r_big ? ewd_pkg::WT_W'(ewd_pkg::SOFT_LIMIT) + ewd_pkg::WT_W'(r_xsq)
                         : ewd_pkg::WT_W'(r_d);
        end
        if (i_cmd.rel_upd && (!r_reach[j] || sum < r_cost[j])) begin
            r_cost[j] <= sum;
            r_hop[j]  <= (r_u == r_src) ? j : r_hop_u;
        end
        if (i_cmd.emit) begin
            r_o_dest  <= j;
            r_o_hop   <= (r_reach[j] && j != r_src) ? r_hop[j] : j;
            r_o_cost  <= r_reach[j] ? r_cost[j] : '1;
            r_o_reach <= r_reach[j];
            r_o_last  <= i_cmd.last;
        end
    end

    assign o_valid      = r_valid;
    assign o_dest_index = r_o_dest;
    assign o_first_hop  = r_o_hop;
    assign o_path_cost  = r_o_cost;
    assign o_reachable  = r_o_reach;
    assign o_last       = r_o_last;

endmodule
